### src/rlm_pkg.sv
// Shared types and constants for the region lookup with mate priority block.
`timescale 1ns / 1ps

package rlm_pkg;

    // field widths
    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 6;
    localparam int CONTIG_W   = 16;
    localparam int POS_W      = 32;
    localparam int ANALYZER_W = 10;
    localparam int IN_DATA_W  = 200;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // saturating match count per side
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_MANY = 2'd2;

    // running match summary for one side of a query
    typedef struct packed {
        logic [1:0]            cnt;
        logic                  is_target;
        logic [ANALYZER_W-1:0] analyzer;
    } side_acc_t;

    // item travelling along the chain of cells
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [INDEX_W-1:0]    index;
        logic [CONTIG_W-1:0]   contig;
        logic [POS_W-1:0]      region_start;
        logic [POS_W-1:0]      region_end;
        logic                  is_target;
        logic [ANALYZER_W-1:0] analyzer;
        logic [CONTIG_W-1:0]   read_contig;
        logic [POS_W-1:0]      read_pos;
        logic [CONTIG_W-1:0]   mate_contig;
        logic [POS_W-1:0]      mate_pos;
        side_acc_t             read_acc;
        side_acc_t             mate_acc;
    } token_t;

    // final answer for one query
    typedef struct packed {
        logic                  found;
        logic                  is_target;
        logic [ANALYZER_W-1:0] analyzer;
        logic                  overlap_error;
    } result_t;

endpackage

### src/rlm_cell.sv
// One table slot: holds a region and matches passing queries against it.
`timescale 1ns / 1ps

module rlm_cell #(
    parameter int CELL_ID = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_vld,
    input  rlm_pkg::token_t in_tok,
    output logic            out_vld,
    output rlm_pkg::token_t out_tok
);

    localparam logic IN_RANGE = (CELL_ID < (1 << rlm_pkg::INDEX_W));
    localparam logic [rlm_pkg::INDEX_W-1:0] MY_INDEX = CELL_ID[rlm_pkg::INDEX_W-1:0];

    logic                           vld_reg, vld_next;
    logic [rlm_pkg::CONTIG_W-1:0]   contig_reg, contig_next;
    logic [rlm_pkg::POS_W-1:0]      start_reg, start_next;
    logic [rlm_pkg::POS_W-1:0]      end_reg, end_next;
    logic                           tgt_reg, tgt_next;
    logic [rlm_pkg::ANALYZER_W-1:0] an_reg, an_next;
    logic                           tok_vld_reg, tok_vld_next;
    rlm_pkg::token_t                tok_reg, tok_next;

    logic write_me;
    logic read_hit;
    logic mate_hit;

    // closed-interval test at 33 bits so position + 1 never wraps
    function automatic logic overlaps(
        input logic [rlm_pkg::CONTIG_W-1:0] q_contig,
        input logic [rlm_pkg::POS_W-1:0]    q_pos,
        input logic                         s_vld,
        input logic [rlm_pkg::CONTIG_W-1:0] s_contig,
        input logic [rlm_pkg::POS_W-1:0]    s_start,
        input logic [rlm_pkg::POS_W-1:0]    s_end
    );
        logic [rlm_pkg::POS_W:0] pos_plus;
        pos_plus = {1'b0, q_pos} + {{rlm_pkg::POS_W{1'b0}}, 1'b1};
        return s_vld && (s_contig == q_contig)
            && ({1'b0, s_start} <= pos_plus) && (s_end >= q_pos);
    endfunction

    // fold one hit into a side summary, keeping the first match's details
    function automatic rlm_pkg::side_acc_t fold(
        input rlm_pkg::side_acc_t           acc,
        input logic                         hit,
        input logic                         s_tgt,
        input logic [rlm_pkg::ANALYZER_W-1:0] s_an
    );
        rlm_pkg::side_acc_t r;
        r = acc;
        if (hit)
        begin
            if (acc.cnt == rlm_pkg::CNT_NONE)
            begin
                r.cnt       = rlm_pkg::CNT_ONE;
                r.is_target = s_tgt;
                r.analyzer  = s_an;
            end
            else
            begin
                r.cnt = rlm_pkg::CNT_MANY;
            end
        end
        return r;
    endfunction

    // slot update and token hand-on
    always_comb
    begin
        write_me = IN_RANGE && (in_tok.index == MY_INDEX);
        read_hit = overlaps(in_tok.read_contig, in_tok.read_pos,
                            vld_reg, contig_reg, start_reg, end_reg);
        mate_hit = overlaps(in_tok.mate_contig, in_tok.mate_pos,
                            vld_reg, contig_reg, start_reg, end_reg);

        vld_next     = vld_reg;
        contig_next  = contig_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        tgt_next     = tgt_reg;
        an_next      = an_reg;
        tok_vld_next = tok_vld_reg;
        tok_next     = tok_reg;

        if (adv)
        begin
            tok_vld_next = in_vld;
            tok_next     = in_tok;
            if (in_vld)
            begin
                case (in_tok.action)
                    rlm_pkg::ACT_LOAD:
                    begin
                        if (write_me)
                        begin
                            vld_next    = 1'b1;
                            contig_next = in_tok.contig;
                            start_next  = in_tok.region_start;
                            end_next    = in_tok.region_end;
                            tgt_next    = in_tok.is_target;
                            an_next     = in_tok.analyzer;
                        end
                    end
                    rlm_pkg::ACT_CLEAR:
                    begin
                        vld_next = 1'b0;
                    end
                    rlm_pkg::ACT_QUERY:
                    begin
                        tok_next.read_acc = fold(in_tok.read_acc, read_hit, tgt_reg, an_reg);
                        tok_next.mate_acc = fold(in_tok.mate_acc, mate_hit, tgt_reg, an_reg);
                    end
                    default:
                    begin
                        tok_vld_next = 1'b0;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    // slot contents and token payload
    always_ff @(posedge clk)
    begin
        contig_reg <= contig_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        tgt_reg    <= tgt_next;
        an_reg     <= an_next;
        tok_reg    <= tok_next;
    end

    assign out_vld = tok_vld_reg;
    assign out_tok = tok_reg;

endmodule

### src/rlm_select.sv
// Priority pick between read and mate summaries at the end of the chain.
`timescale 1ns / 1ps

module rlm_select (
    input  rlm_pkg::side_acc_t read_acc,
    input  rlm_pkg::side_acc_t mate_acc,
    output rlm_pkg::result_t   result
);

    logic read_hit;
    logic mate_hit;

    // read target, mate target, read any, mate any; multiple match is an error
    always_comb
    begin
        read_hit = (read_acc.cnt != rlm_pkg::CNT_NONE);
        mate_hit = (mate_acc.cnt != rlm_pkg::CNT_NONE);
        result   = '0;
        if ((read_acc.cnt == rlm_pkg::CNT_MANY) || (mate_acc.cnt == rlm_pkg::CNT_MANY))
        begin
            result.overlap_error = 1'b1;
        end
        else if (read_hit && read_acc.is_target)
        begin
            result.found     = 1'b1;
            result.is_target = 1'b1;
            result.analyzer  = read_acc.analyzer;
        end
        else if (mate_hit && mate_acc.is_target)
        begin
            result.found     = 1'b1;
            result.is_target = 1'b1;
            result.analyzer  = mate_acc.analyzer;
        end
        else if (read_hit)
        begin
            result.found    = 1'b1;
            result.analyzer = read_acc.analyzer;
        end
        else if (mate_hit)
        begin
            result.found    = 1'b1;
            result.analyzer = mate_acc.analyzer;
        end
    end

endmodule

### src/region_lookup_with_mate_priority.sv
// Top level: region table as a chain of slot cells with a registered result stage.
//
//  channel | dir | tdata fields (low bit up)                         | tuser
//  s_      | in  | entry_index, entry_contig, entry_start, entry_end, | action
//          |     | entry_is_target, entry_analyzer, read_contig,      |
//          |     | read_position, mate_contig, mate_position          |
//  m_      | out | found, locus_is_target, analyzer_id, overlap_error | -
//
// While the chain moves, one transfer is taken per cycle and every item walks the
// chain one cell a cycle; a query passes all slot cells, then the output register.
// Loads and clears follow queries through the chain, so order is kept per slot.
// When the output register holds an untaken result the whole chain freezes.
// Reset clears all slot valid bits and the chain at once; no clearing pass.
`timescale 1ns / 1ps

module region_lookup_with_mate_priority #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index, entry_contig, entry_start, entry_end, entry_is_target,
    // entry_analyzer, read_contig, read_position, mate_contig, mate_position
    input  logic [rlm_pkg::IN_DATA_W-1:0]   s_tdata,
    // action
    input  logic [rlm_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found, locus_is_target, analyzer_id, overlap_error
    output logic [rlm_pkg::OUT_DATA_W-1:0]  m_tdata
);

    logic                     adv;
    logic                     chain_vld [TABLE_DEPTH+1];
    rlm_pkg::token_t          chain_tok [TABLE_DEPTH+1];
    rlm_pkg::result_t         sel_result;
    logic                     m_vld_reg, m_vld_next;
    rlm_pkg::result_t         m_res_reg, m_res_next;

    // the chain moves whenever the output register can take what leaves it
    assign adv      = !m_vld_reg || m_tready;
    assign s_tready = adv;

    // unpack the incoming transfer; unused action codes are dropped here
    always_comb
    begin
        chain_vld[0] = s_tvalid && ((s_tuser == rlm_pkg::ACT_LOAD)
                                 || (s_tuser == rlm_pkg::ACT_QUERY)
                                 || (s_tuser == rlm_pkg::ACT_CLEAR));
        chain_tok[0]              = '0;
        chain_tok[0].action       = s_tuser;
        chain_tok[0].index        = s_tdata[5:0];
        chain_tok[0].contig       = s_tdata[21:6];
        chain_tok[0].region_start = s_tdata[53:22];
        chain_tok[0].region_end   = s_tdata[85:54];
        chain_tok[0].is_target    = s_tdata[86];
        chain_tok[0].analyzer     = s_tdata[96:87];
        chain_tok[0].read_contig  = s_tdata[112:97];
        chain_tok[0].read_pos     = s_tdata[144:113];
        chain_tok[0].mate_contig  = s_tdata[160:145];
        chain_tok[0].mate_pos     = s_tdata[192:161];
    end

    // row of slot cells, slot 0 first
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        rlm_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .in_vld  (chain_vld[i]),
            .in_tok  (chain_tok[i]),
            .out_vld (chain_vld[i+1]),
            .out_tok (chain_tok[i+1])
        );
    end

    rlm_select u_select (
        .read_acc (chain_tok[TABLE_DEPTH].read_acc),
        .mate_acc (chain_tok[TABLE_DEPTH].mate_acc),
        .result   (sel_result)
    );

    // output register: only queries produce a transfer
    always_comb
    begin
        m_vld_next = m_vld_reg;
        m_res_next = m_res_reg;
        if (adv)
        begin
            m_vld_next = chain_vld[TABLE_DEPTH]
                      && (chain_tok[TABLE_DEPTH].action == rlm_pkg::ACT_QUERY);
            m_res_next = sel_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {3'b000, m_res_reg.overlap_error, m_res_reg.analyzer,
                       m_res_reg.is_target, m_res_reg.found};

endmodule

### src/rlm_checker.sv
// Port-level checks for the region lookup top level, bound to it.
`timescale 1ns / 1ps

module rlm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rlm_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // the chain always moves while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // an error result never also reports a region
    a_error_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> !m_tdata[0])
        else $error("found and overlap error together");

    // with nothing found, kind and analyzer read zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[11:1] == 11'd0))
        else $error("details set without a region");

endmodule

bind region_lookup_with_mate_priority rlm_checker u_rlm_checker (.*);
